@@ hdl/mgwc_pkg.sv @@
`default_nettype none
// ============================================================================
// mgwc_pkg: shared types and constants of the weighted centroid core
// Window, frame-total and result records, widths, limits and register map.
// ============================================================================
package mgwc_pkg;

    // raster side length; coordinates at or above it are ignored
    localparam int unsigned C_MAX_SIDE   = 1024;

    // field and accumulator widths
    localparam int unsigned C_COORD_W    = 10;
    localparam int unsigned C_GRAY_W     = 8;
    localparam int unsigned C_WIN_W      = 11;
    localparam int unsigned C_PROD_W     = C_COORD_W + C_GRAY_W;
    localparam int unsigned C_W_W        = 28;
    localparam int unsigned C_M_W        = 38;
    localparam int unsigned C_OUT_W      = 17;

    // divider: numerator 200*m + w, denominator 2*w
    localparam int unsigned C_NUM_W      = C_M_W + 9;
    localparam int unsigned C_DEN_W      = C_W_W + 1;
    localparam int unsigned C_HI_W       = C_NUM_W - C_OUT_W;
    localparam int unsigned C_STEP_W     = $clog2(C_OUT_W);

    // centroid ceiling in hundredths of a pixel
    localparam int unsigned C_LIM_FULL   = (C_MAX_SIDE - 1) * 100;
    localparam int unsigned C_OUT_MAX    = (1 << C_OUT_W) - 1;
    localparam logic [C_OUT_W-1:0] C_OUT_LIM =
        C_OUT_W'((C_LIM_FULL > C_OUT_MAX) ? C_OUT_MAX : C_LIM_FULL);

    // frame-total queue between accumulator and divider
    localparam int unsigned C_Q_DEPTH    = 2;
    localparam int unsigned C_Q_PTR_W    = $clog2(C_Q_DEPTH);
    localparam int unsigned C_Q_CNT_W    = $clog2(C_Q_DEPTH + 1);

    // register map, index = paddr / 4
    localparam int unsigned C_ADDR_W     = 4;
    typedef enum logic [1:0] {
        REG_WIN_LEFT   = 2'd0,
        REG_WIN_TOP    = 2'd1,
        REG_WIN_WIDTH  = 2'd2,
        REG_WIN_HEIGHT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [C_COORD_W-1:0] left;
        logic [C_COORD_W-1:0] top;
        logic [C_WIN_W-1:0]   width;
        logic [C_WIN_W-1:0]   height;
    } t_window;

    typedef struct packed {
        logic [C_W_W-1:0] w;
        logic [C_M_W-1:0] mx;
        logic [C_M_W-1:0] my;
    } t_moments;

    typedef struct packed {
        logic                 empty;
        logic [C_Q_CNT_W-1:0] count;
    } t_q_status;

    typedef struct packed {
        logic               found;
        logic [C_OUT_W-1:0] cy;
        logic [C_OUT_W-1:0] cx;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_SCALE = 3'd1,
        S_CHECK = 3'd2,
        S_DIV   = 3'd3,
        S_DONE  = 3'd4
    } t_back_state;

endpackage
`default_nettype wire

@@ hdl/mgwc_queue.sv @@
`default_nettype none
// ============================================================================
// mgwc_queue: short queue of frame totals
// Holds finished weight and moment sums until the divider takes them.
// ============================================================================
module mgwc_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire mgwc_pkg::t_moments i_data,
    input  wire logic               i_pop,
    output mgwc_pkg::t_moments      o_data,
    output mgwc_pkg::t_q_status     o_status
);
    import mgwc_pkg::*;

    t_moments             r_mem [C_Q_DEPTH];
    logic [C_Q_PTR_W-1:0] r_wr_ptr;
    logic [C_Q_PTR_W-1:0] r_rd_ptr;
    logic [C_Q_CNT_W-1:0] r_count;

    // storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // head of queue
    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule
`default_nettype wire

@@ hdl/mgwc_front.sv @@
`default_nettype none
// ============================================================================
// mgwc_front: pixel classification and moment accumulation
// Tests each pixel against the window, forms gray*x and gray*y, accumulates,
// and hands the frame totals to the queue on the frame-end pixel.
// ============================================================================
module mgwc_front (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire mgwc_pkg::t_window                   i_win,
    input  wire logic                                i_vld,
    output logic                                     o_rdy,
    input  wire logic [mgwc_pkg::C_COORD_W-1:0]      i_x,
    input  wire logic [mgwc_pkg::C_COORD_W-1:0]      i_y,
    input  wire logic                                i_mask,
    input  wire logic [mgwc_pkg::C_GRAY_W-1:0]       i_gray,
    input  wire logic                                i_fe,
    input  wire mgwc_pkg::t_q_status                 i_q_status,
    output logic                                     o_push,
    output mgwc_pkg::t_moments                       o_push_data
);
    import mgwc_pkg::*;

    logic                 x_in_raster;
    logic                 y_in_raster;
    logic                 x_in_win;
    logic                 y_in_win;
    logic                 hit;
    logic                 accept;
    logic                 s1_fe;
    logic [C_W_W-1:0]     n_w;
    logic [C_M_W-1:0]     n_mx;
    logic [C_M_W-1:0]     n_my;

    logic                 r_s1_vld;
    logic                 r_s1_fe;
    logic [C_GRAY_W-1:0]  r_s1_g;
    logic [C_PROD_W-1:0]  r_s1_gx;
    logic [C_PROD_W-1:0]  r_s1_gy;
    logic [C_W_W-1:0]     r_w;
    logic [C_M_W-1:0]     r_mx;
    logic [C_M_W-1:0]     r_my;

    // window and raster test
    always_comb begin
        x_in_raster = (32'(i_x) < C_MAX_SIDE);
        y_in_raster = (32'(i_y) < C_MAX_SIDE);
        x_in_win    = (i_x >= i_win.left) &&
                      (({1'b0, i_x} - {1'b0, i_win.left}) < i_win.width);
        y_in_win    = (i_y >= i_win.top) &&
                      (({1'b0, i_y} - {1'b0, i_win.top}) < i_win.height);
        hit         = i_mask && x_in_raster && y_in_raster && x_in_win && y_in_win;
    end

    // hold off while a frame end could find the queue full
    assign s1_fe  = r_s1_vld && r_s1_fe;
    assign o_rdy  = ((C_Q_CNT_W + 1)'(i_q_status.count) + (C_Q_CNT_W + 1)'(s1_fe))
                    < (C_Q_CNT_W + 1)'(C_Q_DEPTH);
    assign accept = i_vld && o_rdy;

    // stage 1: weights and products, zero when outside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s1_fe  <= 1'b0;
        end else begin
            r_s1_vld <= accept;
            r_s1_fe  <= accept && i_fe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_g  <= hit ? i_gray : '0;
            r_s1_gx <= hit ? C_PROD_W'(i_gray) * C_PROD_W'(i_x) : '0;
            r_s1_gy <= hit ? C_PROD_W'(i_gray) * C_PROD_W'(i_y) : '0;
        end
    end

    // stage 2: running sums, wrapping at their widths
    assign n_w  = r_w  + C_W_W'(r_s1_g);
    assign n_mx = r_mx + C_M_W'(r_s1_gx);
    assign n_my = r_my + C_M_W'(r_s1_gy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w  <= '0;
            r_mx <= '0;
            r_my <= '0;
        end else if (r_s1_vld) begin
            if (r_s1_fe) begin
                r_w  <= '0;
                r_mx <= '0;
                r_my <= '0;
            end else begin
                r_w  <= n_w;
                r_mx <= n_mx;
                r_my <= n_my;
            end
        end
    end

    // frame totals include the frame-end pixel
    assign o_push         = s1_fe;
    assign o_push_data.w  = n_w;
    assign o_push_data.mx = n_mx;
    assign o_push_data.my = n_my;

endmodule
`default_nettype wire

@@ hdl/mgwc_back.sv @@
`default_nettype none
// ============================================================================
// mgwc_back: centroid division and result register
// Two restoring dividers under one sequencer turn frame totals into
// centroids in hundredths of a pixel, rounded half up and saturated.
// ============================================================================
module mgwc_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_vld,
    input  wire mgwc_pkg::t_moments i_q_data,
    output logic                    o_q_pop,
    output logic                    o_m_vld,
    input  wire logic               i_m_rdy,
    output mgwc_pkg::t_result       o_result
);
    import mgwc_pkg::*;

    t_back_state           r_state;
    t_back_state           n_state;
    logic                  load_out;
    logic                  step_last;
    logic [C_DEN_W-1:0]    den;
    logic [C_HI_W-1:0]     num_hi    [2];
    logic [C_DEN_W:0]      trial     [2];
    logic                  trial_ge  [2];
    logic [C_OUT_W-1:0]    cen       [2];
    logic                  found;

    logic [C_W_W-1:0]      r_w;
    logic [C_NUM_W-1:0]    r_num     [2];
    logic [C_DEN_W-1:0]    r_rem     [2];
    logic [C_OUT_W-1:0]    r_lo      [2];
    logic [C_OUT_W-1:0]    r_q       [2];
    logic                  r_sat     [2];
    logic [C_STEP_W-1:0]   r_step;
    logic                  r_out_vld;
    t_result               r_out;

    assign den       = {r_w, 1'b0};
    assign step_last = (r_step == C_STEP_W'(C_OUT_W - 1));
    assign found     = (r_w != '0);

    // per-lane divider terms
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            num_hi[k]   = r_num[k][C_NUM_W-1:C_OUT_W];
            trial[k]    = {r_rem[k], r_lo[k][C_OUT_W-1]};
            trial_ge[k] = (trial[k] >= {1'b0, den});
            cen[k]      = (r_sat[k] || (r_q[k] > C_OUT_LIM)) ? C_OUT_LIM : r_q[k];
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshakes
    always_comb begin
        n_state  = r_state;
        o_q_pop  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_vld) begin
                    o_q_pop = 1'b1;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_CHECK;
            S_CHECK: n_state = S_DIV;
            S_DIV: begin
                if (step_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_m_rdy) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // divider datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_w      <= i_q_data.w;
                r_num[0] <= C_NUM_W'(i_q_data.mx);
                r_num[1] <= C_NUM_W'(i_q_data.my);
            end
            S_SCALE: begin
                // 200*m + w as shifted adds
                for (int k = 0; k < 2; k++) begin
                    r_num[k] <= (r_num[k] << 7) + (r_num[k] << 6) + (r_num[k] << 3)
                              + C_NUM_W'(r_w);
                end
            end
            S_CHECK: begin
                // quotient too big for the output if the high part reaches den
                for (int k = 0; k < 2; k++) begin
                    r_sat[k] <= (num_hi[k] >= C_HI_W'(den));
                    r_rem[k] <= num_hi[k][C_DEN_W-1:0];
                    r_lo[k]  <= r_num[k][C_OUT_W-1:0];
                end
                r_step <= '0;
            end
            S_DIV: begin
                // one restoring step per cycle
                for (int k = 0; k < 2; k++) begin
                    r_rem[k] <= trial_ge[k] ? C_DEN_W'(trial[k] - {1'b0, den})
                                            : trial[k][C_DEN_W-1:0];
                    r_q[k]   <= {r_q[k][C_OUT_W-2:0], trial_ge[k]};
                    r_lo[k]  <= r_lo[k] << 1;
                end
                r_step <= r_step + 1'b1;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (load_out) begin
            r_out_vld <= 1'b1;
        end else if (i_m_rdy) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out.found <= found;
            r_out.cx    <= found ? cen[0] : '0;
            r_out.cy    <= found ? cen[1] : '0;
        end
    end

    assign o_m_vld  = r_out_vld;
    assign o_result = r_out;

endmodule
`default_nettype wire

@@ hdl/masked_gray_weighted_centroid_core.sv @@
`default_nettype none
// ============================================================================
// masked_gray_weighted_centroid_core: windowed gray-weighted centroid
// Accumulates masked pixel weights and moments per frame and reports the
// centroid in hundredths of a pixel for each frame closed by the frame-end pixel.
// ============================================================================
// Pixels are taken one per clock on the slave stream while tready is high and
// accumulated through a two-stage multiply and add pipeline. The frame-end
// pixel (tlast) closes the frame: its totals go into a two-entry queue and the
// accumulators clear, so the next frame can follow it without a gap while
// tready stays high. A sequencer then runs two 17-step restoring dividers side
// by side; a result goes through the scale, check, divide and done states
// before the master stream, and the result register lets the next frame be
// divided while it waits. The divider takes one frame at a time; tready drops
// only when a frame end would find the queue full, which happens when frames
// outpace the divider or while results wait on the master stream.
// Registers (byte address 4*i): window left, top, width, height.
// ============================================================================
module masked_gray_weighted_centroid_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // pixel stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [31:0]                   s_axis_tdata,  // pix_x, pix_y, gray_level
    input  wire logic                          s_axis_tuser,  // mask_on
    input  wire logic                          s_axis_tlast,  // frame_end
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [39:0]                        m_axis_tdata,  // centre_x_centi, centre_y_centi
    output logic                               m_axis_tuser,  // found
    // configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mgwc_pkg::C_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import mgwc_pkg::*;

    t_window    r_win;
    t_reg_idx   reg_idx;
    logic       cfg_wr;
    logic       q_push;
    logic       q_pop;
    t_moments   q_push_data;
    t_moments   q_head;
    t_q_status  q_status;
    t_result    result;

    // register file
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[C_ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.left   <= '0;
            r_win.top    <= '0;
            r_win.width  <= C_WIN_W'(C_MAX_SIDE);
            r_win.height <= C_WIN_W'(C_MAX_SIDE);
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_WIN_LEFT:   r_win.left   <= pwdata[C_COORD_W-1:0];
                REG_WIN_TOP:    r_win.top    <= pwdata[C_COORD_W-1:0];
                REG_WIN_WIDTH:  r_win.width  <= pwdata[C_WIN_W-1:0];
                REG_WIN_HEIGHT: r_win.height <= pwdata[C_WIN_W-1:0];
                default:        r_win        <= r_win;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIN_LEFT:   prdata = 32'(r_win.left);
            REG_WIN_TOP:    prdata = 32'(r_win.top);
            REG_WIN_WIDTH:  prdata = 32'(r_win.width);
            REG_WIN_HEIGHT: prdata = 32'(r_win.height);
            default:        prdata = '0;
        endcase
    end

    // accumulator front
    mgwc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_win       (r_win),
        .i_vld       (s_axis_tvalid),
        .o_rdy       (s_axis_tready),
        .i_x         (s_axis_tdata[9:0]),
        .i_y         (s_axis_tdata[19:10]),
        .i_mask      (s_axis_tuser),
        .i_gray      (s_axis_tdata[27:20]),
        .i_fe        (s_axis_tlast),
        .i_q_status  (q_status),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    // frame-total queue
    mgwc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_push_data),
        .i_pop    (q_pop),
        .o_data   (q_head),
        .o_status (q_status)
    );

    // divider back
    mgwc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_vld  (!q_status.empty),
        .i_q_data (q_head),
        .o_q_pop  (q_pop),
        .o_m_vld  (m_axis_tvalid),
        .i_m_rdy  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {6'b0, result.cy, result.cx};
    assign m_axis_tuser = result.found;

    // a frame total never meets a full queue
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_status.count < C_Q_CNT_W'(C_Q_DEPTH)))
        else $error("frame total pushed into a full queue");

    // every accepted frame end reaches the queue on the next clock
    a_fe_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> q_push)
        else $error("frame end did not produce a queue push");

    // a not-found result carries zero centroids
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("not-found result with nonzero centroid");

    // centroids stay within the saturation ceiling
    a_out_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[16:0] <= C_OUT_LIM) &&
                           (m_axis_tdata[33:17] <= C_OUT_LIM)))
        else $error("centroid above ceiling");

endmodule
`default_nettype wire
